// ----- rtl/separable_3x3_pixel_filter_assert.svh -----
// Concurrent check macros for the pixel filter.
`ifndef SEPARABLE_3X3_PIXEL_FILTER_ASSERT_SVH
`define SEPARABLE_3X3_PIXEL_FILTER_ASSERT_SVH

// same-cycle implication
`define SEP3_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEP3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sep3_pkg.sv -----
`default_nettype none
package sep3_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int COUNT_W     = 23;
   localparam int AREA_W      = WIDTH_W + HEIGHT_W;
   localparam int NFIELDS     = 3;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [HEIGHT_W-1:0] ROW_LIMIT    = 13'd8191;

   typedef logic [NFIELDS-1:0][7:0] pix_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } sep3_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] peak_so_far;
      logic       image_done;
   } sep3_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] addr;
      pix_type          below;
      logic             row_ge1;
      logic             row_ge2;
      logic             emit;
      logic             has_left;
      logic             has_right;
      logic             done;
   } sep3_cmd_type;

   typedef struct packed {
      logic    valid;
      pix_type left;
      pix_type right;
      logic    has_left;
      logic    has_right;
      logic    done;
   } sep3_vert_type;

   // x / 3 for x below 1024
   function automatic logic [8:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = {10'd0, x} * 20'd683;
      return p[19:11];
   endfunction

   function automatic logic [7:0] clamp_byte(input logic [8:0] x);
      return x[8] ? 8'hFF : x[7:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sep3_vert_pass.sv -----
`default_nettype none
module sep3_vert_pass import sep3_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sep3_cmd_type  cmd,
   output sep3_vert_type vert_ff
);

   pix_type above_mem  [MAX_WIDTH];
   pix_type centre_mem [MAX_WIDTH];

   sep3_cmd_type  cmd_ff;
   pix_type       above_rd_ff, centre_rd_ff;
   logic          fwd_ff;
   pix_type       fwd_above_ff, fwd_centre_ff;
   pix_type       win_ff [3];
   pix_type       above_eff, centre_eff, v_in;
   sep3_vert_type vert_in;

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         above_rd_ff  <= above_mem[cmd.addr];
         centre_rd_ff <= centre_mem[cmd.addr];
      end
      if (cmd_ff.valid) begin
         above_mem[cmd_ff.addr]  <= centre_eff;
         centre_mem[cmd_ff.addr] <= cmd_ff.below;
      end
   end

   always_comb begin
      above_eff  = fwd_ff ? fwd_above_ff  : above_rd_ff;
      centre_eff = fwd_ff ? fwd_centre_ff : centre_rd_ff;
      for (int ch = 0; ch < NFIELDS; ch++) begin
         logic [7:0] a;
         logic [9:0] sum;
         a = cmd_ff.row_ge2 ? above_eff[ch] : 8'd0;
         sum = {2'd0, a} + {1'b0, centre_eff[ch], 1'b0} + {2'd0, cmd_ff.below[ch]};
         v_in[ch] = clamp_byte(div3(sum));
      end
      vert_in.valid     = cmd_ff.valid && cmd_ff.emit;
      vert_in.left      = win_ff[1];
      vert_in.right     = v_in;
      vert_in.has_left  = cmd_ff.has_left;
      vert_in.has_right = cmd_ff.has_right;
      vert_in.done      = cmd_ff.done;
   end

   always_ff @(posedge clock) begin
      fwd_above_ff  <= centre_eff;
      fwd_centre_ff <= cmd_ff.below;
      vert_ff.left      <= vert_in.left;
      vert_ff.right     <= vert_in.right;
      vert_ff.has_left  <= vert_in.has_left;
      vert_ff.has_right <= vert_in.has_right;
      vert_ff.done      <= vert_in.done;
      cmd_ff.addr       <= cmd.addr;
      cmd_ff.below      <= cmd.below;
      cmd_ff.row_ge1    <= cmd.row_ge1;
      cmd_ff.row_ge2    <= cmd.row_ge2;
      cmd_ff.emit       <= cmd.emit;
      cmd_ff.has_left   <= cmd.has_left;
      cmd_ff.has_right  <= cmd.has_right;
      cmd_ff.done       <= cmd.done;
      if (reset) begin
         cmd_ff.valid  <= 1'b0;
         fwd_ff        <= 1'b0;
         vert_ff.valid <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         cmd_ff.valid  <= cmd.valid;
         fwd_ff        <= cmd.valid && cmd_ff.valid && (cmd.addr == cmd_ff.addr);
         vert_ff.valid <= vert_in.valid;
         if (cmd_ff.valid && cmd_ff.row_ge1) begin
            if (cmd_ff.done) begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[i] <= '0;
               end
            end else begin
               win_ff[0] <= win_ff[1];
               win_ff[1] <= win_ff[2];
               win_ff[2] <= v_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sep3_horiz_pass.sv -----
`default_nettype none
module sep3_horiz_pass import sep3_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sep3_vert_type vert,
   output logic          push,
   output sep3_rsp_type  push_data
);

   logic [7:0] peak_ff;
   logic [7:0] peak_in;
   pix_type    r;

   always_comb begin
      peak_in = peak_ff;
      for (int ch = 0; ch < NFIELDS; ch++) begin
         logic [7:0] lt, rt, d;
         lt = vert.has_left  ? vert.left[ch]  : 8'd0;
         rt = vert.has_right ? vert.right[ch] : 8'd0;
         d  = (rt > lt) ? rt - lt : 8'd0;
         r[ch] = clamp_byte(div3({2'd0, d}));
         if (r[ch] > peak_in) begin
            peak_in = r[ch];
         end
      end
      push                  = vert.valid;
      push_data.out_red     = r[2];
      push_data.out_green   = r[1];
      push_data.out_blue    = r[0];
      push_data.peak_so_far = peak_in;
      push_data.image_done  = vert.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= 8'd0;
      end else if (vert.valid) begin
         peak_ff <= vert.done ? 8'd0 : peak_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sep3_rsp_fifo.sv -----
`default_nettype none
module sep3_rsp_fifo import sep3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sep3_rsp_type push_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sep3_rsp_type rsp_data
);

   sep3_rsp_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic                    pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/separable_3x3_pixel_filter.sv -----
// The completing pixel passes cmd_ff, then vert_ff, then enters the response queue.
// Throughput: one pixel per clock if req_ready; line stores read and write once per pixel.
// The result for pixel k comes out with stream word k+W+1; W+1 pad words flush an image.
// Reset: synchronous; clears position, counters, window and queue, loads 640x480.
// Line stores are not cleared; they hold garbage until written by the first row.
`default_nettype none
module separable_3x3_pixel_filter import sep3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sep3_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sep3_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

`include "separable_3x3_pixel_filter_assert.svh"

   logic [WIDTH_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [HEIGHT_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0]    count_ff, count_in, count_inc;
   logic [FIFO_CNT_W-1:0] rsv_ff;

   logic [WIDTH_W-1:0]    w_eff, colk;
   logic [HEIGHT_W-1:0]   h_eff;
   logic [AREA_W-1:0]     area;
   logic                  req_fire, rsp_fire, emit, done, wrap;
   sep3_cmd_type          cmd;
   sep3_vert_type         vert;
   logic                  push;
   sep3_rsp_type          push_data;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = 11'd1;
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = 13'd1;
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign area      = {13'd0, w_eff} * {11'd0, h_eff};
   assign req_ready = rsv_ff < FIFO_CNT_W'(FIFO_DEPTH);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      emit      = (row_ff >= 13'd2) || ((row_ff == 13'd1) && (col_ff != '0));
      count_inc = count_ff + 1'b1;
      done      = emit && ({1'b0, count_inc} >= area);
      colk      = (col_ff == '0) ? w_eff - 1'b1 : {1'b0, col_ff} - 1'b1;
      wrap      = ({1'b0, col_ff} + 11'd1) >= w_eff;

      cmd.valid     = req_fire;
      cmd.addr      = col_ff;
      cmd.row_ge1   = row_ff >= 13'd1;
      cmd.row_ge2   = row_ff >= 13'd2;
      cmd.emit      = emit;
      cmd.has_left  = colk != '0;
      cmd.has_right = col_ff != '0;
      cmd.done      = done;
      if (req_data.kind || (row_ff >= h_eff)) begin
         cmd.below = '0;
      end else begin
         cmd.below = {req_data.in_red, req_data.in_green, req_data.in_blue};
      end

      if (done) begin
         col_in   = '0;
         row_in   = '0;
         count_in = '0;
      end else begin
         count_in = emit ? count_inc : count_ff;
         if (wrap) begin
            col_in = '0;
            row_in = (row_ff != ROW_LIMIT) ? row_ff + 1'b1 : row_ff;
         end else begin
            col_in = col_ff + 1'b1;
            row_in = row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         count_ff  <= '0;
         rsv_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            count_ff <= count_in;
         end
         unique case ({req_fire && emit, rsp_fire})
            2'b10:   rsv_ff <= rsv_ff + 1'b1;
            2'b01:   rsv_ff <= rsv_ff - 1'b1;
            default: rsv_ff <= rsv_ff;
         endcase
      end
   end

   sep3_vert_pass u_vert (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .vert_ff (vert)
   );

   sep3_horiz_pass u_horiz (
      .clock     (clock),
      .reset     (reset),
      .vert      (vert),
      .push      (push),
      .push_data (push_data)
   );

   sep3_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `SEP3_ASSERT_IMPLY(a_rsv_bound, 1'b1, rsv_ff <= FIFO_CNT_W'(FIFO_DEPTH), "reservation overrun")
   `SEP3_ASSERT_IMPLY(a_rsp_reserved, rsp_valid, rsv_ff != '0, "result word without reservation")
   `SEP3_ASSERT_NEXT(a_done_restart, req_fire && done, {col_ff, row_ff, count_ff} == '0, "position kept")

endmodule
`default_nettype wire
